// ===== design/tmt_pkg.sv =====
// Timer table package: transfer payload structs, command/result codes and
// the control and status bundles passed between the top level and its cells.
// No dependencies.
`default_nettype none

package tmt_pkg;

	localparam int HANDLE_W = 6;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_SCHED  = 2'd1;
	localparam logic [1:0] CMD_CANCEL = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [1:0] KIND_SCHED  = 2'd0;
	localparam logic [1:0] KIND_FIRE   = 2'd1;
	localparam logic [1:0] KIND_CANCEL = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ERR     = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] period_ticks;
		logic [7:0] repeat_count;
		logic [7:0] callback_tag;
		logic [7:0] cancel_handle;
	} tmt_cmd_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [1:0]          status;
		logic [HANDLE_W-1:0] handle;
		logic [7:0]          tag;
		logic [6:0]          active_count;
		logic                last;
	} tmt_res_t;

	typedef enum logic [2:0] {
		CELL_IDLE,
		CELL_TICK,
		CELL_CLAIM,
		CELL_LOAD,
		CELL_FREE,
		CELL_FREE_ALL
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic                step;
		logic                flush;
		logic [HANDLE_W-1:0] idx;
		logic [7:0]          per;
		logic [7:0]          rep;
		logic [7:0]          tag;
	} cell_ctl_t;

	typedef struct packed {
		logic       free;
		logic       due;
		logic       rep_one;
		logic [7:0] tag;
	} cell_stat_t;

endpackage

`default_nettype wire

// ===== design/tmt_cell.sv =====
// One timer slot of the table plus its stage of the scan token chain.
// Depends on tmt_pkg.
`default_nettype none

module tmt_cell #(
	parameter int IDX = 0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  tmt_pkg::cell_ctl_t  ctl,
	input  wire                 tok_in,
	output logic                tok,
	output tmt_pkg::cell_stat_t stat
);
	import tmt_pkg::*;

	logic [7:0] per_q;
	logic [7:0] rem_q;
	logic [7:0] rep_q;
	logic [7:0] tag_q;
	logic       tok_q;
	logic       act;
	logic       hit;
	logic       free;

	assign free = (per_q == 8'd0);
	assign act  = tok_q && ctl.step;
	assign hit  = (ctl.idx == HANDLE_W'(IDX));
	assign tok  = tok_q;

	assign stat.free    = free;
	assign stat.due     = !free && (rem_q == 8'd1);
	assign stat.rep_one = (rep_q == 8'd1);
	assign stat.tag     = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
			per_q <= 8'd0;
		end else begin
			if (ctl.flush)
				tok_q <= 1'b0;
			else if (ctl.step)
				tok_q <= tok_in;
			case (ctl.op)
				CELL_TICK: begin
					if (act && !free && rem_q == 8'd1 && rep_q == 8'd1)
						per_q <= 8'd0;
				end
				CELL_CLAIM: begin
					if (act && free)
						per_q <= ctl.per;
				end
				CELL_LOAD: begin
					if (hit)
						per_q <= ctl.per;
				end
				CELL_FREE: begin
					if (hit)
						per_q <= 8'd0;
				end
				CELL_FREE_ALL: per_q <= 8'd0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_TICK: begin
				if (act && !free) begin
					if (rem_q != 8'd1) begin
						rem_q <= rem_q - 8'd1;
					end else if (rep_q != 8'd1) begin
						rem_q <= per_q;
						if (rep_q > 8'd1)
							rep_q <= rep_q - 8'd1;
					end else begin
						rem_q <= 8'd0;
					end
				end
			end
			CELL_CLAIM: begin
				if (act && free) begin
					rem_q <= ctl.per;
					rep_q <= ctl.rep;
					tag_q <= ctl.tag;
				end
			end
			CELL_LOAD: begin
				if (hit) begin
					rem_q <= ctl.per;
					rep_q <= ctl.rep;
					tag_q <= ctl.tag;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/multi_entry_software_timer_table.sv =====
// Timer table top level: command decode, scan sequencing and result register
// around a chain of tmt_cell slots.
// Depends on tmt_pkg and tmt_cell.
//
// Usage. Commands arrive on cmd_valid/cmd_stall/cmd_data, one transfer per
// command; results leave on res_valid/res_stall/res_data. A cancel, a
// cancel-all, a refused schedule or a schedule that lands on the slot numbered
// by the active count gives exactly one result, loaded into the result
// register from the decide state once the output is not held by res_stall.
// Any other schedule first scans the chain for the lowest free slot and
// claims it. A tick runs a scan token along the slot chain, one slot per
// cycle, holding the token in every cycle in which a fired slot's result
// waits for the output register. Fire results appear in ascending slot
// order, the final one carrying last; a tick with nothing due gives no
// result. One command is in work at a time: cmd_stall is high from the
// transfer until its work is done. The result register keeps its contents
// while res_stall is high, and the next command is still taken meanwhile.
// Reset frees every slot and zeroes the active count; no clearing pass is
// needed.
`default_nettype none

module multi_entry_software_timer_table #(
	parameter int TABLE_SIZE = 8
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cmd_valid,
	output logic              cmd_stall,
	input  tmt_pkg::tmt_cmd_t cmd_data,
	output logic              res_valid,
	input  wire               res_stall,
	output tmt_pkg::tmt_res_t res_data
);
	import tmt_pkg::*;

	localparam int AW = $clog2(TABLE_SIZE + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_WALK_T,
		S_WALK_S
	} state_t;

	state_t          state_q, state_n;
	tmt_cmd_t        item_q;
	tmt_res_t        res_q, res_n;
	logic            res_vld_q;
	logic            res_ld;
	logic [AW-1:0]   act_q, act_n;
	logic [TABLE_SIZE-1:0] pend_q, pend_n;

	cell_ctl_t       ctl;
	logic            launch;
	logic [TABLE_SIZE:0]   tok_chain;
	logic [TABLE_SIZE-1:0] tokvec;
	logic [TABLE_SIZE-1:0] free_vec;
	logic [TABLE_SIZE-1:0] due_vec;
	cell_stat_t      stat [TABLE_SIZE];

	logic                tok_fire;
	logic                tok_free;
	logic                tok_rep1;
	logic [HANDLE_W-1:0] tok_idx;
	logic [7:0]          tok_tag;
	logic                free_at_act;
	logic                hit_h;
	logic                out_free;

	assign tok_chain[0] = launch;

	for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_cell
		tmt_cell #(.IDX(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.tok_in (tok_chain[g]),
			.tok    (tok_chain[g+1]),
			.stat   (stat[g])
		);
		assign tokvec[g]   = tok_chain[g+1];
		assign free_vec[g] = stat[g].free;
		assign due_vec[g]  = stat[g].due;
	end

	always_comb begin
		tok_idx     = '0;
		tok_tag     = '0;
		tok_rep1    = 1'b0;
		free_at_act = 1'b0;
		hit_h       = 1'b0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if (tokvec[i]) begin
				tok_idx  = tok_idx | HANDLE_W'(i);
				tok_tag  = tok_tag | stat[i].tag;
				tok_rep1 = tok_rep1 | stat[i].rep_one;
			end
			if (free_vec[i] && act_q == AW'(i))
				free_at_act = 1'b1;
			if (!free_vec[i] && item_q.cancel_handle == 8'(i))
				hit_h = 1'b1;
		end
	end

	assign tok_fire  = |(tokvec & due_vec);
	assign tok_free  = |(tokvec & free_vec);
	assign out_free  = !res_vld_q || !res_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = res_vld_q;
	assign res_data  = res_q;

	always_comb begin
		state_n   = state_q;
		act_n     = act_q;
		pend_n    = pend_q;
		launch    = 1'b0;
		res_ld    = 1'b0;
		res_n     = '0;
		ctl.op    = CELL_IDLE;
		ctl.step  = 1'b0;
		ctl.flush = 1'b0;
		ctl.idx   = '0;
		ctl.per   = item_q.period_ticks;
		ctl.rep   = item_q.repeat_count;
		ctl.tag   = item_q.callback_tag;
		res_n.last = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid)
					state_n = S_DECIDE;
			end
			S_DECIDE: begin
				unique case (item_q.cmd)
					CMD_TICK: begin
						launch   = 1'b1;
						ctl.step = 1'b1;
						pend_n   = due_vec;
						state_n  = S_WALK_T;
					end
					CMD_SCHED: begin
						if (out_free) begin
							res_n.kind = KIND_SCHED;
							if (item_q.period_ticks == 8'd0 ||
							    act_q == AW'(TABLE_SIZE)) begin
								res_ld       = 1'b1;
								res_n.status = ST_ERR;
								state_n      = S_IDLE;
							end else if (act_q == '0 || free_at_act) begin
								ctl.op       = CELL_LOAD;
								ctl.idx      = HANDLE_W'(act_q);
								act_n        = act_q + 1'b1;
								res_ld       = 1'b1;
								res_n.status = ST_OK;
								res_n.handle = HANDLE_W'(act_q);
								state_n      = S_IDLE;
							end else begin
								launch   = 1'b1;
								ctl.step = 1'b1;
								state_n  = S_WALK_S;
							end
						end
					end
					CMD_CANCEL: begin
						if (out_free) begin
							res_ld     = 1'b1;
							res_n.kind = KIND_CANCEL;
							state_n    = S_IDLE;
							if ({1'b0, item_q.cancel_handle} < 9'(TABLE_SIZE) &&
							    act_q != '0 && hit_h) begin
								ctl.op       = CELL_FREE;
								ctl.idx      = HANDLE_W'(item_q.cancel_handle);
								act_n        = act_q - 1'b1;
								res_n.status = ST_OK;
							end else begin
								res_n.status = ST_IGNORED;
							end
						end
					end
					CMD_CLEAR: begin
						if (out_free) begin
							ctl.op       = CELL_FREE_ALL;
							act_n        = '0;
							res_ld       = 1'b1;
							res_n.kind   = KIND_CANCEL;
							res_n.status = ST_OK;
							state_n      = S_IDLE;
						end
					end
					default: ;
				endcase
			end
			S_WALK_T: begin
				ctl.op   = CELL_TICK;
				ctl.step = !tok_fire || out_free;
				if (ctl.step) begin
					pend_n = pend_q & ~tokvec;
					if (tok_fire) begin
						if (tok_rep1 && act_q != '0)
							act_n = act_q - 1'b1;
						res_ld       = 1'b1;
						res_n.kind   = KIND_FIRE;
						res_n.status = ST_OK;
						res_n.handle = tok_idx;
						res_n.tag    = tok_tag;
						res_n.last   = ((pend_q & ~tokvec) == '0);
					end
					if (tokvec[TABLE_SIZE-1])
						state_n = S_IDLE;
				end
			end
			S_WALK_S: begin
				ctl.op   = CELL_CLAIM;
				ctl.step = out_free;
				res_n.kind = KIND_SCHED;
				if (out_free) begin
					if (tok_free) begin
						ctl.flush    = 1'b1;
						act_n        = act_q + 1'b1;
						res_ld       = 1'b1;
						res_n.status = ST_OK;
						res_n.handle = tok_idx;
						state_n      = S_IDLE;
					end else if (tokvec[TABLE_SIZE-1]) begin
						res_ld       = 1'b1;
						res_n.status = ST_ERR;
						state_n      = S_IDLE;
					end
				end
			end
			default: state_n = S_IDLE;
		endcase
		res_n.active_count = 7'(act_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_vld_q <= 1'b0;
			act_q     <= '0;
			pend_q    <= '0;
		end else begin
			state_q <= state_n;
			act_q   <= act_n;
			pend_q  <= pend_n;
			if (res_ld)
				res_vld_q <= 1'b1;
			else if (!res_stall)
				res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid)
			item_q <= cmd_data;
		if (res_ld)
			res_q <= res_n;
	end

	a_tok_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tokvec))
		else $error("scan token duplicated");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(~free_vec) == int'(act_q))
		else $error("active count out of step with occupied slots");

	a_tok_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(|tokvec) |-> (state_q == S_WALK_T || state_q == S_WALK_S))
		else $error("scan token outside a walk");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && res_stall) |-> !res_ld)
		else $error("result register overwritten while held");

endmodule

`default_nettype wire

// ===== bench/multi_entry_software_timer_table_test.sv =====
// Testbench for multi_entry_software_timer_table: directed and random commands
// with random idling, checked against a timer table tracked inside the bench.
// Depends on tmt_pkg and the timer table RTL.
`timescale 1ns / 100ps

module multi_entry_software_timer_table_test;

	import tmt_pkg::*;

	localparam int SLOTS       = 8;
	localparam int TAIL_CYCLES = SLOTS + 12;
	localparam int CYCLE_LIMIT = 1000000;

	logic     clk;
	logic     arst_n;
	logic     cmd_valid;
	logic     cmd_stall;
	tmt_cmd_t cmd_data;
	logic     res_valid;
	logic     res_stall;
	tmt_res_t res_data;

	logic [7:0] slot_period  [SLOTS];
	logic [7:0] slot_left    [SLOTS];
	logic [7:0] slot_repeats [SLOTS];
	logic [7:0] slot_tag     [SLOTS];
	int         live_slots;

	tmt_res_t due_results[$];
	int       mismatches;
	int       cycles;
	bit       idle_on;
	int       hold_req;
	int       stall_left;
	int       free_left;

	multi_entry_software_timer_table #(
		.TABLE_SIZE(SLOTS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_data (cmd_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Updates the tracked table and queues the results one command gives.
	function automatic void track_command(input tmt_cmd_t c);
		tmt_res_t r;
		tmt_res_t fired[SLOTS];
		int       n;
		int       pick;
		r = '0;
		n = 0;
		pick = -1;
		case (c.cmd)
			CMD_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_period[i] != 8'd0) begin
						slot_left[i] = slot_left[i] - 8'd1;
						if (slot_left[i] == 8'd0) begin
							if (slot_repeats[i] == 8'd1) begin
								slot_period[i] = 8'd0;
								if (live_slots > 0)
									live_slots--;
							end else begin
								if (slot_repeats[i] > 8'd1)
									slot_repeats[i] = slot_repeats[i] - 8'd1;
								slot_left[i] = slot_period[i];
							end
							r.kind         = KIND_FIRE;
							r.status       = ST_OK;
							r.handle       = HANDLE_W'(i);
							r.tag          = slot_tag[i];
							r.active_count = 7'(live_slots);
							fired[n]       = r;
							n++;
						end
					end
				end
				for (int k = 0; k < n; k++) begin
					r      = fired[k];
					r.last = (k == n - 1);
					due_results.push_back(r);
				end
			end
			CMD_SCHED: begin
				if (c.period_ticks != 8'd0) begin
					if (live_slots == 0)
						pick = 0;
					else if (live_slots < SLOTS) begin
						if (slot_period[live_slots] == 8'd0)
							pick = live_slots;
						else
							for (int i = SLOTS - 1; i >= 0; i--)
								if (slot_period[i] == 8'd0)
									pick = i;
					end
				end
				r.kind = KIND_SCHED;
				r.last = 1'b1;
				if (pick < 0) begin
					r.status = ST_ERR;
				end else begin
					slot_period[pick]  = c.period_ticks;
					slot_left[pick]    = c.period_ticks;
					slot_repeats[pick] = c.repeat_count;
					slot_tag[pick]     = c.callback_tag;
					live_slots++;
					r.status = ST_OK;
					r.handle = HANDLE_W'(pick);
				end
				r.active_count = 7'(live_slots);
				due_results.push_back(r);
			end
			CMD_CANCEL: begin
				r.kind = KIND_CANCEL;
				r.last = 1'b1;
				if (c.cancel_handle >= SLOTS || live_slots == 0 ||
						slot_period[c.cancel_handle] == 8'd0) begin
					r.status = ST_IGNORED;
				end else begin
					slot_period[c.cancel_handle] = 8'd0;
					live_slots--;
					r.status = ST_OK;
				end
				r.active_count = 7'(live_slots);
				due_results.push_back(r);
			end
			default: begin
				for (int i = 0; i < SLOTS; i++)
					slot_period[i] = 8'd0;
				live_slots     = 0;
				r.kind         = KIND_CANCEL;
				r.status       = ST_OK;
				r.last         = 1'b1;
				due_results.push_back(r);
			end
		endcase
	endfunction

	task automatic note_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch in %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		tmt_res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (due_results.size() == 0) begin
				note_mismatch("result with nothing due, kind", res_data.kind, -1);
			end else begin
				want = due_results.pop_front();
				if (res_data.kind != want.kind)
					note_mismatch("kind", res_data.kind, want.kind);
				if (res_data.status != want.status)
					note_mismatch("status", res_data.status, want.status);
				if (res_data.handle != want.handle)
					note_mismatch("handle", res_data.handle, want.handle);
				if (res_data.tag != want.tag)
					note_mismatch("tag", res_data.tag, want.tag);
				if (res_data.active_count != want.active_count)
					note_mismatch("active_count", res_data.active_count,
						want.active_count);
				if (res_data.last != want.last)
					note_mismatch("last", res_data.last, want.last);
			end
		end
	end

	// Result side: random stalls, or one long hold-off on request.
	always @(posedge clk) begin
		bit s;
		if (hold_req > 0) begin
			stall_left = hold_req;
			hold_req   = 0;
			free_left  = 0;
		end
		if (stall_left > 0) begin
			s = 1'b1;
			stall_left--;
		end else if (free_left > 0 || !idle_on) begin
			s = 1'b0;
			if (free_left > 0)
				free_left--;
		end else begin
			stall_left = gap_len();
			free_left  = $urandom_range(1, 12);
			s          = (stall_left > 0);
			if (s)
				stall_left--;
		end
		res_stall <= s;
	end

	task automatic send_cmd(input tmt_cmd_t c);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data  <= c;
		do @(posedge clk); while (cmd_stall);
		track_command(c);
	endtask

	// Sender pauses until every queued result has arrived.
	task automatic settle();
		cmd_valid <= 1'b0;
		while (due_results.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic tmt_cmd_t cmd_of(input logic [1:0] op, input logic [7:0] per,
			input logic [7:0] rep, input logic [7:0] tg, input logic [7:0] h);
		tmt_cmd_t c;
		c.cmd           = op;
		c.period_ticks  = per;
		c.repeat_count  = rep;
		c.callback_tag  = tg;
		c.cancel_handle = h;
		return c;
	endfunction

	function automatic tmt_cmd_t random_cmd();
		tmt_cmd_t c;
		int       r;
		c.period_ticks  = 8'($urandom);
		c.repeat_count  = 8'($urandom);
		c.callback_tag  = 8'($urandom);
		c.cancel_handle = 8'($urandom);
		r = $urandom_range(0, 99);
		if (r < 45) begin
			c.cmd = CMD_TICK;
		end else if (r < 77) begin
			c.cmd = CMD_SCHED;
			r = $urandom_range(0, 99);
			if (r < 85)
				c.period_ticks = 8'($urandom_range(1, 6));
			else if (r < 90)
				c.period_ticks = 8'd0;
			if ($urandom_range(0, 9) < 6)
				c.repeat_count = 8'($urandom_range(0, 4));
		end else if (r < 97) begin
			c.cmd = CMD_CANCEL;
			if ($urandom_range(0, 9) < 8)
				c.cancel_handle = 8'($urandom_range(0, SLOTS - 1));
		end else begin
			c.cmd = CMD_CLEAR;
		end
		return c;
	endfunction

	task automatic test_one_shot_and_errors();
		send_cmd(cmd_of(CMD_SCHED, 8'd1, 8'd1, 8'hFF, 8'd0));
		send_cmd(cmd_of(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
		send_cmd(cmd_of(CMD_SCHED, 8'd0, 8'd3, 8'h11, 8'd0));
		send_cmd(cmd_of(CMD_CANCEL, 8'd0, 8'd0, 8'd0, 8'hFF));
		send_cmd(cmd_of(CMD_SCHED, 8'hFF, 8'd0, 8'h00, 8'd0));
		send_cmd(cmd_of(CMD_CANCEL, 8'd0, 8'd0, 8'd0, 8'd5));
		send_cmd(cmd_of(CMD_CANCEL, 8'd0, 8'd0, 8'd0, 8'd0));
	endtask

	task automatic test_full_table_and_reuse();
		for (int i = 0; i < SLOTS; i++)
			send_cmd(cmd_of(CMD_SCHED, 8'd2, 8'd2, 8'(i * 37 + 3), 8'd0));
		send_cmd(cmd_of(CMD_SCHED, 8'd4, 8'd0, 8'hA5, 8'd0));
		send_cmd(cmd_of(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
		send_cmd(cmd_of(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
		send_cmd(cmd_of(CMD_CANCEL, 8'd0, 8'd0, 8'd0, 8'd3));
		send_cmd(cmd_of(CMD_SCHED, 8'd1, 8'd0, 8'h5A, 8'd0));
		send_cmd(cmd_of(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
		send_cmd(cmd_of(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
		send_cmd(cmd_of(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0));
		send_cmd(cmd_of(CMD_TICK, 8'd0, 8'd0, 8'd0, 8'd0));
	endtask

	task automatic test_output_backpressure();
		idle_on = 1'b0;
		for (int i = 0; i < 4; i++)
			send_cmd(cmd_of(CMD_SCHED, 8'd1, 8'd0, 8'(8'hC0 + i), 8'd0));
		hold_req = 300;
		for (int i = 0; i < 30; i++)
			if (i % 3 == 2)
				send_cmd(random_cmd());
			else
				send_cmd(cmd_of(CMD_TICK, 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom)));
		settle();
		send_cmd(cmd_of(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0));
		settle();
	endtask

	task automatic test_random_traffic(input int count);
		for (int k = 0; k < count; k++) begin
			if (k % 60 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (k % 150 == 149)
				settle();
			send_cmd(random_cmd());
		end
		settle();
	endtask

	initial begin
		arst_n     = 1'b0;
		cmd_valid  = 1'b0;
		cmd_data   = '0;
		res_stall  = 1'b0;
		idle_on    = 1'b1;
		hold_req   = 0;
		stall_left = 0;
		free_left  = 0;
		mismatches = 0;
		cycles     = 0;
		live_slots = 0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_period[i]  = 8'd0;
			slot_left[i]    = 8'd0;
			slot_repeats[i] = 8'd0;
			slot_tag[i]     = 8'd0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_one_shot_and_errors();
		settle();
		test_full_table_and_reuse();
		settle();
		test_output_backpressure();
		test_random_traffic(370);

		if (due_results.size() != 0)
			note_mismatch("results never delivered", 0, due_results.size());
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
